// ----- src/rank_quantile_binner_core_defines.svh -----
// Assertion macros for the rank quantile binner core.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef RANK_QUANTILE_BINNER_CORE_DEFINES_SVH
`define RANK_QUANTILE_BINNER_CORE_DEFINES_SVH

// Condition holds at every edge outside reset.
`define RQB_ASSERT_ALWAYS(lbl, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (c)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RQB_ASSERT_IMPL(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define RQB_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);

`endif

// ----- src/rqb_pkg.sv -----
// Shared types, codes and the float ordering key for the rank quantile binner.
// No dependencies; used by every module of the block.
package rqb_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned BINS_W = 9;
  localparam int unsigned BIN_W  = 8;
  localparam int unsigned Q_W    = 9;

  localparam logic [BINS_W-1:0] BINS_RESET = 9'd64;
  localparam logic [BINS_W-1:0] BINS_MAX   = 9'd256;
  localparam logic [BINS_W-1:0] BINS_MIN   = 9'd1;

  localparam logic [KEY_W-1:0] SIGN_MASK = {1'b1, {(KEY_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2
  } action_t;

  typedef struct packed {
    action_t            action;
    logic [KEY_W-1:0]   intensity;
  } in_t;

  typedef struct packed {
    logic [BIN_W-1:0]   bin;
    logic               set_empty;
    logic               overflowed;
  } out_t;

  // Control bits that travel with a query request down the pipeline.
  typedef struct packed {
    logic vld;
    logic empty;
    logic ovf;
  } tok_flags_t;

  // Map a float bit pattern to an unsigned key with the same ordering.
  function automatic logic [KEY_W-1:0] order_key(input logic [KEY_W-1:0] bits);
    logic [KEY_W-1:0] b;
    b = (bits == SIGN_MASK) ? '0 : bits;
    return b[KEY_W-1] ? ~b : (b | SIGN_MASK);
  endfunction

endpackage

// ----- src/rank_quantile_binner_core.sv -----
// Rank quantile binner: load and clear take effect in the next cycle; a query
// result passes the storage cells of the rank chain, one multiply stage, nine
// divider stages and one output register. Queries enter one per cycle unless
// the output is held; a clear waits until the rank chain is empty.
// Synchronous active-low reset clears fill count, overflow flag, bin count
// (to 64) and pipeline valids; stored values are not cleared.
`include "rank_quantile_binner_core_defines.svh"

module rank_quantile_binner_core #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  rqb_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output rqb_pkg::out_t                out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rqb_pkg::BINS_W-1:0]   cfg_data
);

  localparam int unsigned CW   = $clog2(CAPACITY+1);
  localparam int unsigned PW   = CW + rqb_pkg::Q_W;
  localparam int unsigned QW   = rqb_pkg::Q_W;
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic [CW-1:0]                cnt_r;
  logic                         ovf_r;
  logic [rqb_pkg::BINS_W-1:0]   num_bins_r;
  logic [CW-1:0]                inflight_r;
  logic                         out_valid_r;
  rqb_pkg::out_t                out_data_r;

  rqb_pkg::tok_flags_t          mul_flags_r;
  logic [PW-1:0]                prod_r;
  logic [CW-1:0]                mcnt_r;

  logic                         adv;
  logic                         in_acc;
  logic                         q_acc;
  logic                         ld_acc;
  logic                         clr_acc;
  logic                         drain;
  logic [rqb_pkg::BINS_W-1:0]   bins_eff;
  logic [rqb_pkg::BINS_W-1:0]   bins_m1;
  logic [QW-1:0]                q_clamp;
  rqb_pkg::out_t                out_nxt;

  rqb_pkg::tok_flags_t          ch_flags [0:CAPACITY];
  logic [rqb_pkg::KEY_W-1:0]    ch_key   [0:CAPACITY];
  logic [CW-1:0]                ch_cnt   [0:CAPACITY];
  logic [CW-1:0]                ch_rank  [0:CAPACITY];

  rqb_pkg::tok_flags_t          dv_flags [0:QW];
  logic [PW-1:0]                dv_rem   [0:QW];
  logic [CW-1:0]                dv_cnt   [0:QW];
  logic [QW-1:0]                dv_q     [0:QW];

  // Whole pipeline advances together unless the output register is held.
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv ||
                    ((in_data.action == rqb_pkg::ACT_CLEAR) && (inflight_r != '0));
  assign in_acc   = in_valid && !in_stall;
  assign q_acc    = in_acc && (in_data.action == rqb_pkg::ACT_QUERY);
  assign ld_acc   = in_acc && (in_data.action == rqb_pkg::ACT_LOAD);
  assign clr_acc  = in_acc && (in_data.action == rqb_pkg::ACT_CLEAR);
  assign drain    = adv && ch_flags[CAPACITY].vld;

  assign cfg_ready = 1'b1;

  always_comb begin
    priority if (num_bins_r == '0) begin
      bins_eff = rqb_pkg::BINS_MIN;
    end else if (num_bins_r > rqb_pkg::BINS_MAX) begin
      bins_eff = rqb_pkg::BINS_MAX;
    end else begin
      bins_eff = num_bins_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_bins_r <= rqb_pkg::BINS_RESET;
    end else if (cfg_valid) begin
      num_bins_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (clr_acc) begin
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (ld_acc) begin
      // Drop the load once full and remember it.
      if (cnt_r != CAP_C) begin
        cnt_r <= cnt_r + {{(CW-1){1'b0}}, 1'b1};
      end else begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      unique case ({q_acc, drain})
        2'b10:   inflight_r <= inflight_r + {{(CW-1){1'b0}}, 1'b1};
        2'b01:   inflight_r <= inflight_r - {{(CW-1){1'b0}}, 1'b1};
        default: inflight_r <= inflight_r;
      endcase
    end
  end

  // Chain entry: the query request picks up the fill level and flag now.
  assign ch_flags[0] = '{vld: q_acc, empty: (cnt_r == '0), ovf: ovf_r};
  assign ch_key[0]   = rqb_pkg::order_key(in_data.intensity);
  assign ch_cnt[0]   = cnt_r;
  assign ch_rank[0]  = '0;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    rqb_cell #(
      .CAPACITY (CAPACITY),
      .IDX      (i)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .wr_en     (ld_acc),
      .wr_idx    (cnt_r),
      .wr_key    (ch_key[0]),
      .in_flags  (ch_flags[i]),
      .in_key    (ch_key[i]),
      .in_cnt    (ch_cnt[i]),
      .in_rank   (ch_rank[i]),
      .out_flags (ch_flags[i+1]),
      .out_key   (ch_key[i+1]),
      .out_cnt   (ch_cnt[i+1]),
      .out_rank  (ch_rank[i+1])
    );
  end

  // Scale rank by bin count ahead of the divider.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_flags_r <= '0;
    end else if (adv) begin
      mul_flags_r <= ch_flags[CAPACITY];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= PW'(ch_rank[CAPACITY]) * PW'(bins_eff);
      mcnt_r <= ch_cnt[CAPACITY];
    end
  end

  assign dv_flags[0] = mul_flags_r;
  assign dv_rem[0]   = prod_r;
  assign dv_cnt[0]   = mcnt_r;
  assign dv_q[0]     = '0;

  // Quotient never exceeds the bin count, so nine bits cover it.
  for (genvar k = 0; k < QW; k++) begin : g_div
    rqb_div_cell #(
      .CAPACITY (CAPACITY),
      .BIT      (QW - 1 - k)
    ) u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .in_flags  (dv_flags[k]),
      .in_rem    (dv_rem[k]),
      .in_cnt    (dv_cnt[k]),
      .in_q      (dv_q[k]),
      .out_flags (dv_flags[k+1]),
      .out_rem   (dv_rem[k+1]),
      .out_cnt   (dv_cnt[k+1]),
      .out_q     (dv_q[k+1])
    );
  end

  assign bins_m1 = bins_eff - rqb_pkg::BINS_MIN;
  assign q_clamp = (dv_q[QW] > bins_m1) ? bins_m1 : dv_q[QW];

  always_comb begin
    out_nxt.bin        = dv_flags[QW].empty ? '0 : q_clamp[rqb_pkg::BIN_W-1:0];
    out_nxt.set_empty  = dv_flags[QW].empty;
    out_nxt.overflowed = dv_flags[QW].ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_flags[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `RQB_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CAP_C, "fill count above capacity")
  `RQB_ASSERT_NEXT(a_clear_resets, clr_acc, (cnt_r == '0) && !ovf_r, "clear did not reset set")
  `RQB_ASSERT_NEXT(a_ovf_on_full, ld_acc && (cnt_r == CAP_C), ovf_r, "dropped load not flagged")
  `RQB_ASSERT_IMPL(a_clear_idle, clr_acc, inflight_r == '0, "clear taken with queries in chain")

endmodule

// ----- src/rqb_cell.sv -----
// One storage cell of the rank chain: holds one ordering key and adds its
// less-than vote to the passing query. Depends on rqb_pkg.
module rqb_cell #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned IDX      = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             adv,
  input  logic                             wr_en,
  input  logic [$clog2(CAPACITY+1)-1:0]    wr_idx,
  input  logic [rqb_pkg::KEY_W-1:0]        wr_key,
  input  rqb_pkg::tok_flags_t              in_flags,
  input  logic [rqb_pkg::KEY_W-1:0]        in_key,
  input  logic [$clog2(CAPACITY+1)-1:0]    in_cnt,
  input  logic [$clog2(CAPACITY+1)-1:0]    in_rank,
  output rqb_pkg::tok_flags_t              out_flags,
  output logic [rqb_pkg::KEY_W-1:0]        out_key,
  output logic [$clog2(CAPACITY+1)-1:0]    out_cnt,
  output logic [$clog2(CAPACITY+1)-1:0]    out_rank
);

  localparam int unsigned CW = $clog2(CAPACITY+1);
  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic [rqb_pkg::KEY_W-1:0] val_r;
  rqb_pkg::tok_flags_t       flags_r;
  logic [rqb_pkg::KEY_W-1:0] key_r;
  logic [CW-1:0]             cnt_r;
  logic [CW-1:0]             rank_r;
  logic                      hit;
  logic [CW-1:0]             rank_nxt;

  // Count only entries below the fill level seen at query time.
  assign hit      = (in_cnt > IDX_C) && (val_r < in_key);
  assign rank_nxt = in_rank + {{(CW-1){1'b0}}, hit};

  always_ff @(posedge clk) begin
    if (wr_en && (wr_idx == IDX_C)) begin
      val_r <= wr_key;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (adv) begin
      flags_r <= in_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r  <= in_key;
      cnt_r  <= in_cnt;
      rank_r <= rank_nxt;
    end
  end

  assign out_flags = flags_r;
  assign out_key   = key_r;
  assign out_cnt   = cnt_r;
  assign out_rank  = rank_r;

endmodule

// ----- src/rqb_div_cell.sv -----
// One quotient bit of the pipelined restoring divider behind the rank chain.
// Depends on rqb_pkg.
module rqb_div_cell #(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned BIT      = 0
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           adv,
  input  rqb_pkg::tok_flags_t                            in_flags,
  input  logic [$clog2(CAPACITY+1)+rqb_pkg::Q_W-1:0]     in_rem,
  input  logic [$clog2(CAPACITY+1)-1:0]                  in_cnt,
  input  logic [rqb_pkg::Q_W-1:0]                        in_q,
  output rqb_pkg::tok_flags_t                            out_flags,
  output logic [$clog2(CAPACITY+1)+rqb_pkg::Q_W-1:0]     out_rem,
  output logic [$clog2(CAPACITY+1)-1:0]                  out_cnt,
  output logic [rqb_pkg::Q_W-1:0]                        out_q
);

  localparam int unsigned CW = $clog2(CAPACITY+1);
  localparam int unsigned PW = CW + rqb_pkg::Q_W;

  rqb_pkg::tok_flags_t       flags_r;
  logic [PW-1:0]             rem_r;
  logic [CW-1:0]             cnt_r;
  logic [rqb_pkg::Q_W-1:0]   q_r;
  logic [PW-1:0]             dvs;
  logic                      ge;
  logic [PW-1:0]             rem_nxt;
  logic [rqb_pkg::Q_W-1:0]   q_nxt;

  assign dvs = PW'(in_cnt) << BIT;
  assign ge  = (in_rem >= dvs);

  always_comb begin
    rem_nxt = ge ? (in_rem - dvs) : in_rem;
    q_nxt      = in_q;
    q_nxt[BIT] = ge;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
    end else if (adv) begin
      flags_r <= in_flags;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_r <= rem_nxt;
      cnt_r <= in_cnt;
      q_r   <= q_nxt;
    end
  end

  assign out_flags = flags_r;
  assign out_rem   = rem_r;
  assign out_cnt   = cnt_r;
  assign out_q     = q_r;

endmodule

// ----- tb/rank_quantile_binner_core_tb.sv -----
// Self-checking bench for rank_quantile_binner_core: load/clear/query requests
// with random gaps and output stalls, predicted bins compared per result.
// Depends on rqb_pkg for the request and result types and the action codes.
`timescale 1ns / 1ps

module rank_quantile_binner_core_tb;

  localparam int unsigned CAPACITY    = 1024;
  localparam int unsigned PIPE_LAT    = CAPACITY + 11;
  localparam int unsigned STALL_LIMIT = 6 * (PIPE_LAT + 100);

  logic                       clk;
  logic                       rst_n     = 1'b0;
  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  rqb_pkg::in_t               in_data   = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  rqb_pkg::out_t              out_data;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [rqb_pkg::BINS_W-1:0] cfg_data  = '0;

  // Predicted state of the binner.
  logic [rqb_pkg::KEY_W-1:0]  set_keys [CAPACITY];
  int unsigned                set_count = 0;
  logic                       set_ovf   = 1'b0;
  logic [rqb_pkg::BINS_W-1:0] bins_reg  = rqb_pkg::BINS_RESET;
  logic [rqb_pkg::KEY_W-1:0]  loaded_raw [$];
  rqb_pkg::out_t              pending_bins [$];

  int unsigned       errors      = 0;
  int unsigned       idle_cycles = 0;
  int unsigned       hold_cnt    = 0;
  bit                steady      = 1'b0;

  rank_quantile_binner_core #(
    .CAPACITY(CAPACITY)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Fold -0 onto +0, then flip so unsigned compare follows float order.
  function automatic logic [rqb_pkg::KEY_W-1:0] float_rank_key(
    input logic [rqb_pkg::KEY_W-1:0] raw
  );
    logic [rqb_pkg::KEY_W-1:0] v;
    v = (raw == 32'h8000_0000) ? 32'h0 : raw;
    return v[rqb_pkg::KEY_W-1] ? ~v : {1'b1, v[rqb_pkg::KEY_W-2:0]};
  endfunction

  function automatic rqb_pkg::out_t bin_predict(input logic [rqb_pkg::KEY_W-1:0] raw);
    rqb_pkg::out_t             r;
    logic [rqb_pkg::KEY_W-1:0] key;
    int unsigned               rank;
    int unsigned               eff;
    int unsigned               q;
    key          = float_rank_key(raw);
    eff          = (bins_reg == 0) ? 1 : (bins_reg > 256) ? 256 : bins_reg;
    r.bin        = '0;
    r.set_empty  = 1'b0;
    r.overflowed = set_ovf;
    if (set_count == 0) begin
      r.set_empty = 1'b1;
    end else begin
      rank = 0;
      for (int i = 0; i < set_count; i++) begin
        if (set_keys[i] < key) rank++;
      end
      q = (rank * eff) / set_count;
      if (q > eff - 1) q = eff - 1;
      r.bin = 8'(q);
    end
    return r;
  endfunction

  task automatic apply_request(input rqb_pkg::action_t act,
                               input logic [rqb_pkg::KEY_W-1:0] raw);
    case (act)
      rqb_pkg::ACT_CLEAR: begin
        set_count = 0;
        set_ovf   = 1'b0;
        loaded_raw.delete();
      end
      rqb_pkg::ACT_LOAD: begin
        if (set_count < CAPACITY) begin
          set_keys[set_count] = float_rank_key(raw);
          set_count++;
          loaded_raw = {loaded_raw, raw};
        end else begin
          set_ovf = 1'b1;
        end
      end
      rqb_pkg::ACT_QUERY: pending_bins = {pending_bins, bin_predict(raw)};
      default: ;
    endcase
  endtask

  function automatic int unsigned idle_gap();
    int unsigned roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_request(input rqb_pkg::action_t act,
                              input logic [rqb_pkg::KEY_W-1:0] raw);
    int unsigned gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{action: act, intensity: raw};
    do @(posedge clk); while (in_stall);
    apply_request(act, raw);
  endtask

  // Hold off until every query has its result and the pipe has emptied.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_bins.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  task automatic write_bins(input logic [rqb_pkg::BINS_W-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    bins_reg = v;
  endtask

  function automatic logic [rqb_pkg::KEY_W-1:0] special_value(input int unsigned idx);
    case (idx)
      0:       return 32'h0000_0000;
      1:       return 32'h8000_0000;
      2:       return 32'h7F80_0000;
      3:       return 32'hFF80_0000;
      4:       return 32'h7FC0_0000;
      5:       return 32'hFFC0_0000;
      6:       return 32'h0000_0001;
      7:       return 32'h8000_0001;
      8:       return 32'h7F7F_FFFF;
      9:       return 32'hFF7F_FFFF;
      10:      return 32'hFFFF_FFFF;
      default: return 32'h7FFF_FFFF;
    endcase
  endfunction

  function automatic logic [rqb_pkg::KEY_W-1:0] pick_intensity();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30 || loaded_raw.size() == 0) return $urandom;
    if (roll < 55) return loaded_raw[$urandom_range(0, loaded_raw.size() - 1)];
    if (roll < 70) begin
      if ($urandom_range(0, 1) == 0)
        return loaded_raw[$urandom_range(0, loaded_raw.size() - 1)] + 32'd1;
      return loaded_raw[$urandom_range(0, loaded_raw.size() - 1)] - 32'd1;
    end
    if (roll < 85) return special_value($urandom_range(0, 11));
    // narrow range around 1.0 and -1.0 to make ties likely
    return {1'(roll[0]), 8'h7F, 19'h0, 4'($urandom_range(0, 15))};
  endfunction

  task automatic test_directed_edges();
    send_request(rqb_pkg::ACT_QUERY, 32'h3F80_0000);          // empty set
    send_request(rqb_pkg::action_t'(2'd3), 32'h3F80_0000);    // unused code, no load
    send_request(rqb_pkg::ACT_QUERY, 32'h3F80_0000);
    send_request(rqb_pkg::ACT_LOAD,  32'h8000_0000);          // negative zero
    send_request(rqb_pkg::ACT_QUERY, 32'h0000_0000);
    send_request(rqb_pkg::ACT_QUERY, 32'h0000_0001);          // rank equals count, clamp
    for (int i = 2; i < 12; i++) begin
      if (i != 6 && i != 9) send_request(rqb_pkg::ACT_LOAD, special_value(i));
    end
    send_request(rqb_pkg::ACT_LOAD,  32'h0000_0001);
    send_request(rqb_pkg::ACT_QUERY, 32'h8000_0000);
    send_request(rqb_pkg::ACT_QUERY, 32'hFFFF_FFFF);
    send_request(rqb_pkg::ACT_QUERY, 32'h7FFF_FFFF);
    send_request(rqb_pkg::ACT_QUERY, 32'hFF80_0000);
    send_request(rqb_pkg::ACT_QUERY, 32'h7F80_0000);
    send_request(rqb_pkg::ACT_CLEAR, 32'h0);
    send_request(rqb_pkg::ACT_QUERY, 32'h7F80_0000);
    send_request(rqb_pkg::action_t'(2'd3), 32'h0);
  endtask

  task automatic run_random_set(input int unsigned n_items);
    int unsigned roll;
    send_request(rqb_pkg::ACT_CLEAR, $urandom);
    for (int i = 0; i < n_items; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < 48)      send_request(rqb_pkg::ACT_LOAD, pick_intensity());
      else if (roll < 92) send_request(rqb_pkg::ACT_QUERY, pick_intensity());
      else if (roll < 96) send_request(rqb_pkg::ACT_CLEAR, $urandom);
      else                send_request(rqb_pkg::action_t'(2'd3), $urandom);
    end
  endtask

  task automatic test_bin_extremes();
    logic [rqb_pkg::BINS_W-1:0] settings [8];
    settings = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd2, 9'd255, 9'd257, 9'd128};
    for (int s = 0; s < 8; s++) begin
      write_bins(settings[s]);
      run_random_set($urandom_range(3, 6));
    end
  endtask

  task automatic test_random_sets();
    for (int s = 0; s < 4; s++) begin
      if ($urandom_range(0, 1) == 0) write_bins(9'($urandom_range(0, 511)));
      steady = (s % 2 == 1);
      run_random_set($urandom_range(4, 14));
    end
    steady = 1'b0;
  endtask

  task automatic test_capacity_overflow();
    logic [rqb_pkg::KEY_W-1:0] pool [16];
    for (int i = 0; i < 16; i++) pool[i] = $urandom;
    write_bins(rqb_pkg::BINS_MAX);
    send_request(rqb_pkg::ACT_CLEAR, 32'h0);
    for (int i = 0; i < CAPACITY + 4; i++) begin
      if ($urandom_range(0, 1) == 0) send_request(rqb_pkg::ACT_LOAD, pool[$urandom_range(0, 15)]);
      else                           send_request(rqb_pkg::ACT_LOAD, $urandom);
      if (i % 128 == 0 || i >= CAPACITY - 2) send_request(rqb_pkg::ACT_QUERY, pick_intensity());
    end
    for (int i = 0; i < 12; i++) send_request(rqb_pkg::ACT_QUERY, pick_intensity());
    send_request(rqb_pkg::ACT_CLEAR, 32'h0);
    send_request(rqb_pkg::ACT_QUERY, 32'h3F80_0000);          // flag gone after clear
    send_request(rqb_pkg::ACT_LOAD,  32'h3F80_0000);
    send_request(rqb_pkg::ACT_QUERY, 32'h4000_0000);
  endtask

  task automatic test_drain_pause();
    send_request(rqb_pkg::ACT_CLEAR, 32'h0);
    for (int i = 0; i < 8; i++) send_request(rqb_pkg::ACT_LOAD, pick_intensity());
    for (int i = 0; i < 6; i++) send_request(rqb_pkg::ACT_QUERY, pick_intensity());
    wait_idle();
    for (int i = 0; i < 6; i++) send_request(rqb_pkg::ACT_QUERY, pick_intensity());
    send_request(rqb_pkg::ACT_LOAD, pick_intensity());
    send_request(rqb_pkg::ACT_QUERY, pick_intensity());
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_bin_extremes();
    test_random_sets();
    test_capacity_overflow();
    test_drain_pause();
    wait_idle();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Output backpressure: mostly short runs, a few long stalls.
  always @(posedge clk) begin : stall_gen
    int unsigned roll;
    if (steady) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        out_stall <= 1'b0;
        hold_cnt  <= $urandom_range(0, 15);
      end else if (roll < 96) begin
        out_stall <= 1'b1;
        hold_cnt  <= $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b1;
        hold_cnt  <= $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk) begin : result_check
    rqb_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_bins.size() == 0) begin
        $display("%0t: unexpected result bin %0d empty %0b ovf %0b", $time,
                 out_data.bin, out_data.set_empty, out_data.overflowed);
        errors++;
      end else begin
        want = pending_bins.pop_front();
        if (out_data.bin !== want.bin) begin
          $display("%0t: bin expected %0d actual %0d", $time, want.bin, out_data.bin);
          errors++;
        end
        if (out_data.set_empty !== want.set_empty) begin
          $display("%0t: set_empty expected %0b actual %0b", $time,
                   want.set_empty, out_data.set_empty);
          errors++;
        end
        if (out_data.overflowed !== want.overflowed) begin
          $display("%0t: overflowed expected %0b actual %0b", $time,
                   want.overflowed, out_data.overflowed);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ----- sim.f -----
+incdir+src
src/rqb_pkg.sv
src/rqb_cell.sv
src/rqb_div_cell.sv
src/rank_quantile_binner_core.sv
tb/rank_quantile_binner_core_tb.sv
